@@ rtl/nsat_pkg.sv @@
package nsat_pkg;

    localparam int SLOTS   = 8;
    localparam int ROW     = 8;
    localparam int SLOT_W  = 3;
    localparam int CHAN_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int ADDR_W  = CHAN_W + SLOT_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int DATA_W  = NOTE_W + VEL_W;

    localparam logic [ROW-1:0] SLOT_MASK = ROW'((1 << SLOTS) - 1);

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_KEY_ON   = 2'd2,
        OP_KEY_OFF  = 2'd3
    } t_op;

    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_tbl_cmd;

    function automatic logic [SLOT_W-1:0] first_set(input logic [ROW-1:0] mask);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = ROW - 1; k >= 0; k--) begin
            if (mask[k]) begin
                idx = SLOT_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/note_slot_assignment_table_unit.sv @@
// note slot assignment table
// input channel: i_in_valid / o_in_stall carries one event item (opcode, channel,
// slot, all_slots, note, velocity); accepted when valid is high and stall is low
// output channel: o_out_valid / i_out_stall carries one message item per slot
// touched by a key event, slots in ascending order, o_last on the final one
// score events produce no items; key events touching no slot produce none
// one item is worked on at a time; o_in_stall is high until it is finished
// score note-on: the event is registered, then the first free slot is written
// other events: the event is registered, S_INIT takes the row's valid flags,
// then each slot visited takes one table read (S_SCAN) and one decision (S_DATA);
// a note-off that finds its note ends at that decision; the registered read
// sets the per-slot pair; the first message is registered out after S_INIT,
// S_SCAN and S_DATA, then one more per slot pair while the receiver takes them
// when the receiver stalls, the message is held and the scan waits on it
// reset empties both tables at once by clearing per-entry valid flags; no
// clearing pass is needed and the unit accepts an item right after reset
module note_slot_assignment_table_unit
    import nsat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [CHAN_W-1:0] i_channel,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_all_slots,
    input  logic [NOTE_W-1:0] i_note,
    input  logic [VEL_W-1:0]  i_velocity,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_note_on,
    output logic [NOTE_W-1:0] o_out_note,
    output logic [VEL_W-1:0]  o_out_velocity,
    output logic [CHAN_W-1:0] o_out_channel,
    output logic              o_last
);

    t_tbl_cmd          cmd_a, cmd_s;
    logic [CHAN_W-1:0] row;
    logic [ROW-1:0]    row_valid_a, row_valid_s;
    logic [DATA_W-1:0] rd_data_a, rd_data_s;

    nsat_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_channel      (i_channel),
        .i_slot         (i_slot),
        .i_all_slots    (i_all_slots),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .o_cmd_a        (cmd_a),
        .o_cmd_s        (cmd_s),
        .o_row          (row),
        .i_row_valid_a  (row_valid_a),
        .i_row_valid_s  (row_valid_s),
        .i_rd_data_a    (rd_data_a),
        .i_rd_data_s    (rd_data_s),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_note_on   (o_is_note_on),
        .o_out_note     (o_out_note),
        .o_out_velocity (o_out_velocity),
        .o_out_channel  (o_out_channel),
        .o_last         (o_last)
    );

    // assigned score notes
    nsat_table u_assigned (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_a),
        .i_row       (row),
        .o_row_valid (row_valid_a),
        .o_rd_data   (rd_data_a)
    );

    // sounding notes
    nsat_table u_sounding (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_s),
        .i_row       (row),
        .o_row_valid (row_valid_s),
        .o_rd_data   (rd_data_s)
    );

endmodule

@@ rtl/nsat_table.sv @@
module nsat_table
    import nsat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [CHAN_W-1:0] i_row,
    output logic [ROW-1:0]    o_row_valid,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;

    // entry valid flags, cleared together at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[i_cmd.addr] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_valid[i_cmd.addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_cmd.addr] <= i_cmd.wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    assign o_row_valid = r_valid[{i_row, SLOT_W'(0)} +: ROW];
    assign o_rd_data   = r_rd_data;

    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |=> r_valid[$past(i_cmd.addr)])
        else $error("written entry not marked valid");

    a_clr_drops_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clr && !i_cmd.wr) |=> !r_valid[$past(i_cmd.addr)])
        else $error("cleared entry still valid");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr && i_cmd.clr))
        else $error("write and clear together");

endmodule

@@ rtl/nsat_seq.sv @@
module nsat_seq
    import nsat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [CHAN_W-1:0] i_channel,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_all_slots,
    input  logic [NOTE_W-1:0] i_note,
    input  logic [VEL_W-1:0]  i_velocity,
    output t_tbl_cmd          o_cmd_a,
    output t_tbl_cmd          o_cmd_s,
    output logic [CHAN_W-1:0] o_row,
    input  logic [ROW-1:0]    i_row_valid_a,
    input  logic [ROW-1:0]    i_row_valid_s,
    input  logic [DATA_W-1:0] i_rd_data_a,
    input  logic [DATA_W-1:0] i_rd_data_s,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_note_on,
    output logic [NOTE_W-1:0] o_out_note,
    output logic [VEL_W-1:0]  o_out_velocity,
    output logic [CHAN_W-1:0] o_out_channel,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_SCAN = 4'b0100,
        S_DATA = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_all, n_all;
    logic [NOTE_W-1:0] r_note, n_note;
    logic [VEL_W-1:0]  r_vel, n_vel;
    logic [ROW-1:0]    r_mask, n_mask;
    logic [SLOT_W-1:0] r_cur, n_cur;

    logic              r_out_valid, n_out_valid;
    logic              r_out_on, n_out_on;
    logic [NOTE_W-1:0] r_out_note, n_out_note;
    logic [VEL_W-1:0]  r_out_vel, n_out_vel;
    logic              r_out_last, n_out_last;

    logic              accept;
    logic              out_free;
    logic              emit;
    logic [ROW-1:0]    sel;
    logic [ROW-1:0]    free;
    logic [ROW-1:0]    rest;
    logic [DATA_W-1:0] rd_data;
    t_tbl_cmd          cmd_a, cmd_s;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign sel      = (r_all ? SLOT_MASK : (ROW'(1) << r_slot)) & SLOT_MASK;
    assign free     = ~i_row_valid_a & SLOT_MASK;
    assign rest     = r_mask & ~(ROW'(1) << r_cur);
    assign rd_data  = (r_op == OP_KEY_OFF) ? i_rd_data_s : i_rd_data_a;
    assign emit     = (r_state == S_DATA) && out_free
                      && ((r_op == OP_KEY_ON) || (r_op == OP_KEY_OFF));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_chan      = r_chan;
        n_slot      = r_slot;
        n_all       = r_all;
        n_note      = r_note;
        n_vel       = r_vel;
        n_mask      = r_mask;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_on    = r_out_on;
        n_out_note  = r_out_note;
        n_out_vel   = r_out_vel;
        n_out_last  = r_out_last;
        cmd_a       = '0;
        cmd_s       = '0;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // zero velocity note-on behaves as note-off
                    if (t_op'(i_opcode) == OP_NOTE_ON && i_velocity == '0) begin
                        n_op = OP_NOTE_OFF;
                    end else begin
                        n_op = t_op'(i_opcode);
                    end
                    n_chan  = i_channel;
                    n_slot  = i_slot;
                    n_all   = i_all_slots;
                    n_note  = i_note;
                    n_vel   = i_velocity;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                case (r_op)
                    OP_NOTE_ON: begin
                        if (free != '0) begin
                            cmd_a.wr    = 1'b1;
                            cmd_a.addr  = {r_chan, first_set(free)};
                            cmd_a.wdata = {r_note, r_vel};
                        end
                        n_state = S_IDLE;
                    end
                    OP_NOTE_OFF: begin
                        n_mask  = i_row_valid_a & SLOT_MASK;
                        n_state = S_SCAN;
                    end
                    OP_KEY_ON: begin
                        n_mask  = i_row_valid_a & sel;
                        n_state = S_SCAN;
                    end
                    OP_KEY_OFF: begin
                        n_mask  = i_row_valid_s & sel;
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_mask == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur = first_set(r_mask);
                    if (r_op == OP_KEY_OFF) begin
                        cmd_s.rd   = 1'b1;
                        cmd_s.addr = {r_chan, first_set(r_mask)};
                    end else begin
                        cmd_a.rd   = 1'b1;
                        cmd_a.addr = {r_chan, first_set(r_mask)};
                    end
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (r_op == OP_NOTE_OFF) begin
                    if (rd_data[DATA_W-1:VEL_W] == r_note) begin
                        cmd_a.clr  = 1'b1;
                        cmd_a.addr = {r_chan, r_cur};
                        n_mask     = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_mask  = rest;
                        n_state = S_SCAN;
                    end
                end else if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_on    = (r_op == OP_KEY_ON);
                    n_out_note  = rd_data[DATA_W-1:VEL_W];
                    n_out_vel   = rd_data[VEL_W-1:0];
                    n_out_last  = (rest == '0);
                    cmd_s.addr  = {r_chan, r_cur};
                    if (r_op == OP_KEY_ON) begin
                        cmd_s.wr    = 1'b1;
                        cmd_s.wdata = rd_data;
                    end else begin
                        cmd_s.clr = 1'b1;
                    end
                    n_mask  = rest;
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mask      <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_chan     <= n_chan;
        r_slot     <= n_slot;
        r_all      <= n_all;
        r_note     <= n_note;
        r_vel      <= n_vel;
        r_cur      <= n_cur;
        r_out_on   <= n_out_on;
        r_out_note <= n_out_note;
        r_out_vel  <= n_out_vel;
        r_out_last <= n_out_last;
    end

    // output channel field holds the channel of the message last emitted
    logic [CHAN_W-1:0] r_out_chan;
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_chan <= r_chan;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cmd_a        = cmd_a;
    assign o_cmd_s        = cmd_s;
    assign o_row          = r_chan;
    assign o_out_valid    = r_out_valid;
    assign o_is_note_on   = r_out_on;
    assign o_out_note     = r_out_note;
    assign o_out_velocity = r_out_vel;
    assign o_out_channel  = r_out_chan;
    assign o_last         = r_out_last;

    a_data_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> ($past(r_state) == S_SCAN || $past(r_state) == S_DATA))
        else $error("read data used without a read");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_out_last) |=> (r_mask == '0))
        else $error("final item flagged with slots left");

    a_no_cross_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_s.wr && (cmd_a.wr || cmd_a.clr)))
        else $error("both tables written in one cycle");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_note)))
        else $error("stalled item overwritten");

endmodule

@@ test/note_slot_assignment_table_unit_tb.sv @@
module note_slot_assignment_table_unit_tb;
    import nsat_pkg::*;

    localparam int N_RANDOM   = 425;
    localparam int N_QUIET    = 60;
    localparam int WATCHDOG   = 1000;
    localparam int DRAIN_WAIT = 40;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        logic              vld;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_slot_entry;

    typedef struct packed {
        logic              on;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [CHAN_W-1:0] ch;
        logic              last;
    } t_note_msg;

    typedef struct packed {
        t_op               op;
        logic [CHAN_W-1:0] ch;
        logic [SLOT_W-1:0] sl;
        logic              all;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        bit                fixed;
        bit                fixed_n;
        t_note_msg         msg;
    } t_score_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_opcode;
    logic [CHAN_W-1:0] i_channel;
    logic [SLOT_W-1:0] i_slot;
    logic              i_all_slots;
    logic [NOTE_W-1:0] i_note;
    logic [VEL_W-1:0]  i_velocity;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_is_note_on;
    logic [NOTE_W-1:0] o_out_note;
    logic [VEL_W-1:0]  o_out_velocity;
    logic [CHAN_W-1:0] o_out_channel;
    logic              o_last;

    t_slot_entry assign_tab [1<<CHAN_W][ROW];
    t_slot_entry sound_tab  [1<<CHAN_W][ROW];
    t_note_msg   pending_msgs[$];
    t_score_row  dir_rows[N_DIRECTED];

    bit          quiet = 1'b0;
    int          mismatches = 0;
    int          msgs_seen = 0;
    int          idle_cycles = 0;
    int          op_count[4] = '{0, 0, 0, 0};
    t_note_msg   want, got;

    note_slot_assignment_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_channel      (i_channel),
        .i_slot         (i_slot),
        .i_all_slots    (i_all_slots),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_note_on   (o_is_note_on),
        .o_out_note     (o_out_note),
        .o_out_velocity (o_out_velocity),
        .o_out_channel  (o_out_channel),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_score_row mk_row(t_op op, int ch, int sl, int all, int note, int vel,
                                          int chk, int n, int on, int onote, int ovel);
        t_score_row r;
        r.op      = op;
        r.ch      = CHAN_W'(ch);
        r.sl      = SLOT_W'(sl);
        r.all     = all[0];
        r.note    = NOTE_W'(note);
        r.vel     = VEL_W'(vel);
        r.fixed   = chk[0];
        r.fixed_n = n[0];
        r.msg     = {on[0], NOTE_W'(onote), VEL_W'(ovel), CHAN_W'(ch), 1'b1};
        return r;
    endfunction

    function automatic string msg_text(input t_note_msg m);
        return $sformatf("on=%0b note=%0d vel=%0d ch=%0d last=%0b",
                         m.on, m.note, m.vel, m.ch, m.last);
    endfunction

    task automatic table_step(input t_op op_in, input logic [CHAN_W-1:0] ch,
                              input logic [SLOT_W-1:0] sl, input logic all,
                              input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel,
                              input bit push);
        t_op       op;
        bit        done;
        int        n;
        t_note_msg m;
        op   = op_in;
        done = 1'b0;
        n    = 0;
        if (op == OP_NOTE_ON && vel == '0) begin
            op = OP_NOTE_OFF;
        end
        case (op)
            OP_NOTE_ON: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && !assign_tab[ch][i].vld) begin
                        assign_tab[ch][i] = {1'b1, note, vel};
                        done = 1'b1;
                    end
                end
            end
            OP_NOTE_OFF: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && assign_tab[ch][i].vld && assign_tab[ch][i].note == note) begin
                        assign_tab[ch][i] = '0;
                        done = 1'b1;
                    end
                end
            end
            default: begin
                if (all || sl < SLOTS) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (all || i == sl) begin
                            if (op == OP_KEY_ON && assign_tab[ch][i].vld) begin
                                m = {1'b1, assign_tab[ch][i].note, assign_tab[ch][i].vel,
                                     ch, 1'b0};
                                sound_tab[ch][i] = assign_tab[ch][i];
                                n++;
                                if (push) pending_msgs.push_back(m);
                            end else if (op == OP_KEY_OFF && sound_tab[ch][i].vld) begin
                                m = {1'b0, sound_tab[ch][i].note, sound_tab[ch][i].vel,
                                     ch, 1'b0};
                                sound_tab[ch][i] = '0;
                                n++;
                                if (push) pending_msgs.push_back(m);
                            end
                        end
                    end
                end
            end
        endcase
        if (push && n > 0) begin
            m = pending_msgs[pending_msgs.size() - 1];
            m.last = 1'b1;
            pending_msgs[pending_msgs.size() - 1] = m;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_event(input t_score_row r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_opcode    = r.op;
        i_channel   = r.ch;
        i_slot      = r.sl;
        i_all_slots = r.all;
        i_note      = r.note;
        i_velocity  = r.vel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        op_count[r.op]++;
        table_step(r.op, r.ch, r.sl, r.all, r.note, r.vel, !r.fixed);
        if (r.fixed && r.fixed_n) begin
            pending_msgs.push_back(r.msg);
        end
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected %s, got %s", what, msg_text(want), msg_text(got));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            msgs_seen++;
            got = {o_is_note_on, o_out_note, o_out_velocity, o_out_channel, o_last};
            if (pending_msgs.size() == 0) begin
                want = 'x;
                report_mismatch("unexpected message");
            end else begin
                want = pending_msgs.pop_front();
                if (got !== want) begin
                    report_mismatch("message mismatch");
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG);
            $display("FAIL note_slot_assignment_table_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls in bursts, none in the closing stretch
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                repeat (60) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
            if (!quiet) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        t_score_row r;
        int         pick;
        int         sel;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_NOTE_ON;
        i_channel   = '0;
        i_slot      = '0;
        i_all_slots = 1'b0;
        i_note      = '0;
        i_velocity  = '0;
        for (int c = 0; c < (1 << CHAN_W); c++) begin
            for (int s = 0; s < ROW; s++) begin
                assign_tab[c][s] = '0;
                sound_tab[c][s]  = '0;
            end
        end

        //                       op           ch sl al note vel chk n on note vel
        dir_rows[0]  = mk_row(OP_KEY_ON,    0, 0, 1,   0,   0, 1, 0, 0,   0,   0);
        dir_rows[1]  = mk_row(OP_KEY_OFF,  15, 7, 0,   0,   0, 1, 0, 0,   0,   0);
        dir_rows[2]  = mk_row(OP_NOTE_ON,   0, 0, 0,   0,   1, 1, 0, 0,   0,   0);
        dir_rows[3]  = mk_row(OP_KEY_ON,    0, 0, 0,   0,   0, 1, 1, 1,   0,   1);
        dir_rows[4]  = mk_row(OP_NOTE_ON,  15, 0, 0, 127, 127, 1, 0, 0,   0,   0);
        dir_rows[5]  = mk_row(OP_KEY_ON,   15, 0, 0,   0,   0, 1, 1, 1, 127, 127);
        // repeated key-on sends the slot again
        dir_rows[6]  = mk_row(OP_KEY_ON,   15, 0, 0,   0,   0, 1, 1, 1, 127, 127);
        dir_rows[7]  = mk_row(OP_KEY_OFF,  15, 0, 1,   0,   0, 1, 1, 0, 127, 127);
        dir_rows[8]  = mk_row(OP_KEY_OFF,  15, 0, 1,   0,   0, 1, 0, 0,   0,   0);
        // fill channel 5, note 64 held twice
        dir_rows[9]  = mk_row(OP_NOTE_ON,   5, 0, 0,   0, 127, 0, 0, 0,   0,   0);
        dir_rows[10] = mk_row(OP_NOTE_ON,   5, 0, 0, 127,   1, 0, 0, 0,   0,   0);
        dir_rows[11] = mk_row(OP_NOTE_ON,   5, 0, 0,  64,  85, 0, 0, 0,   0,   0);
        dir_rows[12] = mk_row(OP_NOTE_ON,   5, 0, 0,  63,  42, 0, 0, 0,   0,   0);
        dir_rows[13] = mk_row(OP_NOTE_ON,   5, 0, 0,  64, 100, 0, 0, 0,   0,   0);
        dir_rows[14] = mk_row(OP_NOTE_ON,   5, 0, 0,   1, 127, 0, 0, 0,   0,   0);
        dir_rows[15] = mk_row(OP_NOTE_ON,   5, 0, 0, 126,  64, 0, 0, 0,   0,   0);
        dir_rows[16] = mk_row(OP_NOTE_ON,   5, 0, 0,  85,   1, 0, 0, 0,   0,   0);
        // full channel drops the note
        dir_rows[17] = mk_row(OP_NOTE_ON,   5, 0, 0,  99,  50, 0, 0, 0,   0,   0);
        // zero velocity frees the lowest slot holding 64
        dir_rows[18] = mk_row(OP_NOTE_ON,   5, 0, 0,  64,   0, 0, 0, 0,   0,   0);
        dir_rows[19] = mk_row(OP_NOTE_OFF,  5, 0, 0, 120,   9, 0, 0, 0,   0,   0);
        dir_rows[20] = mk_row(OP_KEY_ON,    5, 0, 1,   0,   0, 0, 0, 0,   0,   0);
        dir_rows[21] = mk_row(OP_NOTE_ON,   5, 0, 0,  99,  50, 0, 0, 0,   0,   0);
        dir_rows[22] = mk_row(OP_KEY_ON,    5, 2, 0,   0,   0, 1, 1, 1,  99,  50);
        dir_rows[23] = mk_row(OP_KEY_OFF,   5, 0, 1,   0,   0, 0, 0, 0,   0,   0);
        dir_rows[24] = mk_row(OP_KEY_OFF,   0, 0, 0,   0,   0, 1, 1, 0,   0,   1);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_event(dir_rows[k]);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            quiet = (k >= N_RANDOM - N_QUIET);
            r = mk_row(OP_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            r.ch   = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 15))
                                                 : CHAN_W'($urandom_range(0, 3));
            r.sl   = SLOT_W'($urandom_range(0, 7));
            r.all  = ($urandom_range(0, 2) == 0);
            r.note = ($urandom_range(0, 1) == 0) ? NOTE_W'($urandom_range(0, 127))
                                                 : NOTE_W'($urandom_range(60, 63));
            r.vel  = VEL_W'($urandom_range(0, 127));
            pick   = $urandom_range(0, 99);
            if (pick < 38) begin
                r.op = OP_NOTE_ON;
                r.vel = ($urandom_range(0, 7) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
            end else if (pick < 58) begin
                r.op = OP_NOTE_OFF;
                // mostly release a note that is actually held
                sel = $urandom_range(0, 7);
                if ($urandom_range(0, 3) != 0 && assign_tab[r.ch][sel].vld) begin
                    r.note = assign_tab[r.ch][sel].note;
                end
            end else if (pick < 80) begin
                r.op = OP_KEY_ON;
            end else begin
                r.op = OP_KEY_OFF;
            end
            send_event(r);
        end
        i_in_valid = 1'b0;

        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d event items: %0d note-on, %0d note-off, %0d key-on, %0d key-off",
                 N_DIRECTED + N_RANDOM, op_count[OP_NOTE_ON], op_count[OP_NOTE_OFF],
                 op_count[OP_KEY_ON], op_count[OP_KEY_OFF]);
        $display("%0d note messages checked, %0d mismatches", msgs_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS note_slot_assignment_table_unit");
        end else begin
            $display("FAIL note_slot_assignment_table_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/nsat_pkg.sv
rtl/nsat_table.sv
rtl/nsat_seq.sv
rtl/note_slot_assignment_table_unit.sv
test/note_slot_assignment_table_unit_tb.sv
